@@ rtl/sgcr_pkg.sv @@
package sgcr_pkg;
    localparam logic [1:0] REQ_ADD_BLOCK = 2'd0;
    localparam logic [1:0] REQ_LOAD      = 2'd1;
    localparam logic [1:0] REQ_TEXT      = 2'd2;
    localparam logic [1:0] REQ_END       = 2'd3;

    localparam logic [1:0] REG_HALF = 2'd0;
    localparam logic [1:0] REG_FULL = 2'd1;
    localparam logic [1:0] REG_LINE = 2'd2;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [15:0] block_start;
        logic [15:0] block_end;
        logic [12:0] glyph_index;
        logic [63:0] glyph_rows;
        logic [7:0]  text_byte;
    } t_req;

    typedef struct packed {
        logic        kind;
        logic [7:0]  column_bits;
        logic [9:0]  column_pos;
        logic [9:0]  used_width;
        logic        last;
    } t_res;

    function automatic logic [63:0] transpose_rows(input logic [63:0] rows);
        logic [63:0] cols;
        cols = '0;
        for (int r = 0; r < 8; r++) begin
            for (int c = 0; c < 8; c++) begin
                cols[8*c + r] = rows[8*r + 7 - c];
            end
        end
        return cols;
    endfunction
endpackage

@@ rtl/sgcr_if.sv @@
interface sgcr_req_if;
    import sgcr_pkg::*;
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface sgcr_res_if;
    import sgcr_pkg::*;
    logic valid;
    logic ready;
    t_res data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ rtl/sgcr_block_table.sv @@
// Block range table: appended by add requests, searched one entry per cycle.
module sgcr_block_table #(
    parameter int MAX_BLOCKS = 128,
    parameter int GLYPH_SLOTS = 8192
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_add,
    input  logic [15:0]                    i_start,
    input  logic [15:0]                    i_end,
    input  logic                           i_search,
    input  logic [15:0]                    i_code,
    output logic                           o_done,
    output logic                           o_hit,
    output logic [$clog2(GLYPH_SLOTS)-1:0] o_slot
);
    localparam int AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam int SW = $clog2(GLYPH_SLOTS);

    logic [15:0] r_first [MAX_BLOCKS];
    logic [15:0] r_lastc [MAX_BLOCKS];
    logic [SW-1:0] r_base [MAX_BLOCKS];
    logic [CW-1:0] r_count;
    logic [SW-1:0] r_next_base;

    logic          r_busy, r_rd_v;
    logic [CW-1:0] r_idx;
    logic [15:0]   r_rf, r_rl;
    logic [SW-1:0] r_rb;
    logic [16:0]   span;

    assign span = {1'b0, i_end} - {1'b0, i_start} + 17'd1;

    always_ff @(posedge i_clk) begin
        if (i_add && r_count < CW'(MAX_BLOCKS)) begin
            r_first[r_count[AW-1:0]] <= i_start;
            r_lastc[r_count[AW-1:0]] <= i_end;
            r_base[r_count[AW-1:0]]  <= r_next_base;
        end
        r_rf <= r_first[r_idx[AW-1:0]];
        r_rl <= r_lastc[r_idx[AW-1:0]];
        r_rb <= r_base[r_idx[AW-1:0]];
    end

    logic [15:0] diff;
    assign diff = i_code - r_rf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_next_base <= '0;
            r_busy <= 1'b0;
            r_rd_v <= 1'b0;
            r_idx <= '0;
            o_done <= 1'b0;
            o_hit <= 1'b0;
        end else begin
            if (i_add && r_count < CW'(MAX_BLOCKS)) begin
                r_count <= r_count + 1'b1;
                if (i_end >= i_start) r_next_base <= r_next_base + SW'(span);
            end
            if (i_search) begin
                o_done <= 1'b0;
                r_idx <= '0;
                r_rd_v <= 1'b0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_rd_v && i_code >= r_rf && i_code <= r_rl) begin
                    o_done <= 1'b1; o_hit <= 1'b1; r_busy <= 1'b0;
                    o_slot <= SW'(256) + r_rb + SW'(diff);
                end else if (r_rd_v ? (r_idx >= r_count) : (r_count == '0)) begin
                    o_done <= 1'b1; o_hit <= 1'b0; r_busy <= 1'b0;
                end else begin
                    o_done <= 1'b0;
                end
                // r_idx runs one ahead of the registered read data
                if (r_idx < r_count) r_idx <= r_idx + 1'b1;
                r_rd_v <= (r_idx < r_count);
            end else begin
                o_done <= 1'b0;
            end
        end
    end
endmodule

@@ rtl/sjis_glyph_column_renderer.sv @@
// Channel  | Dir | Payload
// req      | in  | req_type, block_start, block_end, glyph_index, glyph_rows, text_byte
// res      | out | kind, column_bits, column_pos, used_width, last
// apb      | cfg | half_width@0, full_width@4, line_width@8
// A double-byte code goes through the block search, which reads one table entry
// per cycle. Each column and the end report wait on res ready. Reset is
// synchronous; the glyph memory needs no clearing.
module sjis_glyph_column_renderer #(
    parameter int MAX_BLOCKS = 128,
    parameter int GLYPH_SLOTS = 8192
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sgcr_req_if.sink    req,
    sgcr_res_if.source  res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import sgcr_pkg::*;
    localparam int SW = $clog2(GLYPH_SLOTS);

    localparam logic [2:0] S_IDLE = 3'd0, S_SEARCH = 3'd1, S_READ = 3'd2,
                           S_WAIT = 3'd3, S_EMIT = 3'd4, S_OUT = 3'd5;

    logic [3:0] r_half, r_full;
    logic [9:0] r_line;
    assign pready = 1'b1;
    always_comb begin
        unique case (paddr[3:2])
            REG_HALF: prdata = {28'd0, r_half};
            REG_FULL: prdata = {28'd0, r_full};
            REG_LINE: prdata = {22'd0, r_line};
            default:  prdata = '0;
        endcase
    end

    logic [63:0] r_mem [GLYPH_SLOTS];
    logic [63:0] r_cols;
    logic [2:0]  r_state;
    t_req        r_req;
    logic [8:0]  r_lead;
    logic [9:0]  r_ccount;
    logic [3:0]  r_w, r_j;
    logic [SW-1:0] r_slot;
    logic        r_ov;
    t_res        r_out;

    logic tb_add, tb_search, tb_done, tb_hit;
    logic [SW-1:0] tb_slot;
    logic [15:0] code;
    assign code = {r_lead[7:0], r_req.text_byte};
    assign tb_add = (r_state == S_IDLE) && req.valid && req.data.req_type == REQ_ADD_BLOCK;

    sgcr_block_table #(.MAX_BLOCKS(MAX_BLOCKS), .GLYPH_SLOTS(GLYPH_SLOTS)) u_tbl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_add(tb_add),
        .i_start(req.data.block_start), .i_end(req.data.block_end),
        .i_search(tb_search), .i_code(code),
        .o_done(tb_done), .o_hit(tb_hit), .o_slot(tb_slot));

    assign req.ready = (r_state == S_IDLE);
    assign res.valid = r_ov;
    assign res.data  = r_out;

    logic is_lead;
    assign is_lead = (r_req.text_byte >= 8'h81 && r_req.text_byte <= 8'h9F) ||
                     (r_req.text_byte >= 8'hE0 && r_req.text_byte <= 8'hFC);
    assign tb_search = (r_state == S_SEARCH) && r_lead[8];

    // a new result is loaded into the output register this cycle
    logic ov_set;
    assign ov_set = ((r_state == S_IDLE) && req.valid && (req.data.req_type == REQ_END)) ||
                    ((r_state == S_EMIT) && (!r_ov || res.ready) &&
                     (r_j < r_w) && (r_ccount < r_line));

    always_ff @(posedge i_clk) begin
        if (req.valid && req.ready && req.data.req_type == REQ_LOAD)
            r_mem[SW'(req.data.glyph_index)] <= transpose_rows(req.data.glyph_rows);
        r_cols <= r_mem[r_slot];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half <= 4'd6; r_full <= 4'd8; r_line <= 10'd128;
            r_state <= S_IDLE; r_lead <= '0; r_ccount <= '0; r_ov <= 1'b0;
        end else begin
            if (psel && penable && pwrite) begin
                unique case (paddr[3:2])
                    REG_HALF: r_half <= pwdata[3:0];
                    REG_FULL: r_full <= pwdata[3:0];
                    REG_LINE: r_line <= pwdata[9:0];
                    default: ;
                endcase
            end
            if (ov_set) r_ov <= 1'b1;
            else if (res.ready) r_ov <= 1'b0;
            unique case (r_state)
                S_IDLE: if (req.valid) begin
                    r_req <= req.data;
                    if (req.data.req_type == REQ_TEXT) r_state <= S_SEARCH;
                    else if (req.data.req_type == REQ_END) begin
                        r_out <= '{kind: 1'b1, column_bits: 8'd0, column_pos: 10'd0,
                                   used_width: r_ccount, last: 1'b1};
                        r_ccount <= '0; r_lead <= '0;
                        r_state <= S_OUT;
                    end
                end
                S_SEARCH: begin
                    if (r_lead[8]) begin
                        // lead stays held so the search code is stable
                        r_w <= (r_full > 4'd8) ? 4'd8 : r_full;
                        r_state <= S_WAIT;
                    end else if (is_lead) begin
                        r_lead <= {1'b1, r_req.text_byte};
                        r_state <= S_IDLE;
                    end else begin
                        r_w <= (r_half > 4'd8) ? 4'd8 : r_half;
                        r_slot <= SW'(r_req.text_byte);
                        r_state <= S_READ;
                    end
                    r_j <= '0;
                end
                S_WAIT: if (tb_done) begin
                    r_lead <= '0;
                    r_slot <= tb_slot;
                    r_state <= tb_hit ? S_READ : S_IDLE;
                end
                S_READ: r_state <= S_EMIT; // memory read latency
                S_EMIT: if (!r_ov || res.ready) begin
                    if (r_j >= r_w || r_ccount >= r_line) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_out <= '{kind: 1'b0, column_bits: r_cols[8*r_j[2:0] +: 8],
                                   column_pos: r_ccount, used_width: 10'd0,
                                   last: (r_j + 4'd1 >= r_w) || (r_ccount + 10'd1 >= r_line)};
                        r_ccount <= r_ccount + 10'd1;
                        r_j <= r_j + 4'd1;
                    end
                end
                S_OUT: if (res.ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
